// File: rtl/core/dakep_pkg.sv
// ----------------------------------------------------------------------------
// dakep_pkg
// Types, codes and helpers shared by the dual alarm / key / serial event
// picker.
// ----------------------------------------------------------------------------
package dakep_pkg;

    localparam int LEVEL_W = 16;
    localparam int LIMIT_W = 8;
    localparam int CODE_W  = 8;
    localparam int KIND_W  = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_A1_HIGH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_A1_LOW  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_A2_HIGH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_A2_LOW  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT  = 3'd4;

    // event kinds
    localparam logic [KIND_W-1:0] EV_NONE       = 4'd0;
    localparam logic [KIND_W-1:0] EV_A1_HIGH    = 4'd1;
    localparam logic [KIND_W-1:0] EV_A1_LOW     = 4'd2;
    localparam logic [KIND_W-1:0] EV_A1_OK      = 4'd3;
    localparam logic [KIND_W-1:0] EV_A2_HIGH    = 4'd4;
    localparam logic [KIND_W-1:0] EV_A2_LOW     = 4'd5;
    localparam logic [KIND_W-1:0] EV_A2_OK      = 4'd6;
    localparam logic [KIND_W-1:0] EV_KEY        = 4'd7;
    localparam logic [KIND_W-1:0] EV_UP         = 4'd8;
    localparam logic [KIND_W-1:0] EV_LEFT       = 4'd9;
    localparam logic [KIND_W-1:0] EV_DOWN       = 4'd10;
    localparam logic [KIND_W-1:0] EV_MOVE_RIGHT = 4'd11;
    localparam logic [KIND_W-1:0] EV_SELECT     = 4'd12;

    // offsets from an alarm's base event code
    localparam logic [1:0] OFF_HIGH = 2'd0;
    localparam logic [1:0] OFF_LOW  = 2'd1;
    localparam logic [1:0] OFF_OK   = 2'd2;

    // serial command bytes
    localparam logic [CODE_W-1:0] CH_UP    = 8'h77; // w
    localparam logic [CODE_W-1:0] CH_LEFT  = 8'h61; // a
    localparam logic [CODE_W-1:0] CH_DOWN  = 8'h73; // s
    localparam logic [CODE_W-1:0] CH_RIGHT = 8'h64; // d
    localparam logic [CODE_W-1:0] CH_ENTER = 8'h20; // space
    localparam logic [CODE_W-1:0] CH_NONE  = 8'h00;

    // floor(10*x/11) == (x * 29790) >> 15, exact for x < 256
    localparam logic [14:0] DECAY_MUL   = 15'd29790;
    localparam int          DECAY_SHIFT = 15;

    typedef struct packed {
        logic [LEVEL_W-1:0] level_one;
        logic [LEVEL_W-1:0] level_two;
        logic               key_down;
        logic [CODE_W-1:0]  key_value;
        logic [CODE_W-1:0]  serial_char;
    } dakep_item_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] a1_high;
        logic [LEVEL_W-1:0] a1_low;
        logic [LEVEL_W-1:0] a2_high;
        logic [LEVEL_W-1:0] a2_low;
        logic [LIMIT_W-1:0] repeat_limit;
    } dakep_cfg_t;

    typedef struct packed {
        logic       hit;
        logic [1:0] off;
        logic [1:0] flags;   // {low, high}
        logic       lamp;
    } dakep_chan_t;

    function automatic dakep_chan_t chan_check(
        input logic [LEVEL_W-1:0] level,
        input logic [LEVEL_W-1:0] hi,
        input logic [LEVEL_W-1:0] lo,
        input logic [1:0]         flags,
        input logic               lamp
    );
        dakep_chan_t r;
        r.hit   = 1'b0;
        r.off   = OFF_HIGH;
        r.flags = flags;
        r.lamp  = lamp;
        if (level >= hi) begin
            if (!flags[0]) begin
                r.hit      = 1'b1;
                r.off      = OFF_HIGH;
                r.flags[0] = 1'b1;
                r.lamp     = 1'b1;
            end
        end else if (level <= lo) begin
            if (!flags[1]) begin
                r.hit      = 1'b1;
                r.off      = OFF_LOW;
                r.flags[1] = 1'b1;
                r.lamp     = 1'b1;
            end
        end else if (flags != 2'b00) begin
            r.hit   = 1'b1;
            r.off   = OFF_OK;
            r.flags = 2'b00;
            r.lamp  = 1'b0;
        end
        return r;
    endfunction

    function automatic logic [KIND_W-1:0] decode_serial(input logic [CODE_W-1:0] c);
        logic [KIND_W-1:0] k;
        case (c)
            CH_UP:    k = EV_UP;
            CH_LEFT:  k = EV_LEFT;
            CH_DOWN:  k = EV_DOWN;
            CH_RIGHT: k = EV_MOVE_RIGHT;
            CH_ENTER: k = EV_SELECT;
            default:  k = EV_NONE;
        endcase
        return k;
    endfunction

    function automatic logic [LIMIT_W-1:0] decay(input logic [LIMIT_W-1:0] x);
        logic [LIMIT_W+15-1:0] p;
        p = (LIMIT_W + 15)'(x) * (LIMIT_W + 15)'(DECAY_MUL);
        return p[DECAY_SHIFT +: LIMIT_W];
    endfunction

endpackage

// File: rtl/core/dakep_cfg_regs.sv
// ----------------------------------------------------------------------------
// dakep_cfg_regs
// Configuration register file: alarm limits and key repeat limit.
// ----------------------------------------------------------------------------
module dakep_cfg_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [dakep_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dakep_pkg::CFG_DATA_W-1:0]   cfg_data,
    output dakep_pkg::dakep_cfg_t              cfg
);
    import dakep_pkg::*;

    dakep_cfg_t cfg_reg;
    dakep_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_A1_HIGH: cfg_next.a1_high      = cfg_data;
                CFG_A1_LOW:  cfg_next.a1_low       = cfg_data;
                CFG_A2_HIGH: cfg_next.a2_high      = cfg_data;
                CFG_A2_LOW:  cfg_next.a2_low       = cfg_data;
                CFG_REPEAT:  cfg_next.repeat_limit = cfg_data[LIMIT_W-1:0];
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.a1_high      <= '1;
            cfg_reg.a1_low       <= '0;
            cfg_reg.a2_high      <= '1;
            cfg_reg.a2_low       <= '0;
            cfg_reg.repeat_limit <= LIMIT_W'(50);
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: rtl/core/dakep_pick.sv
// ----------------------------------------------------------------------------
// dakep_pick
// Picks one event per beat from alarms, keypad and serial byte; holds the
// alarm/key state and the result register.
// ----------------------------------------------------------------------------
module dakep_pick (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              go,
    input  dakep_pkg::dakep_item_t            item,
    input  dakep_pkg::dakep_cfg_t             cfg,
    input  logic                              out_ready,
    output logic                              out_valid,
    output logic [dakep_pkg::KIND_W-1:0]      event_kind,
    output logic [dakep_pkg::CODE_W-1:0]      event_key,
    output logic                              lamp_one,
    output logic                              lamp_two
);
    import dakep_pkg::*;

    logic [3:0]         flags_reg,  flags_next;
    logic [1:0]         lamp_reg,   lamp_next;
    logic [CODE_W:0]    prev_reg,   prev_next;
    logic [LIMIT_W-1:0] hold_reg,   hold_next;
    logic               out_valid_reg, out_valid_next;
    logic [KIND_W-1:0]  kind_reg,   kind_next;
    logic [CODE_W-1:0]  key_reg,    key_next;

    dakep_chan_t        ch1, ch2;
    logic [CODE_W:0]    key_now;
    logic [LIMIT_W-1:0] hold_inc;
    logic               taken;

    assign ch1 = chan_check(item.level_one, cfg.a1_high, cfg.a1_low,
                            flags_reg[1:0], lamp_reg[0]);
    assign ch2 = chan_check(item.level_two, cfg.a2_high, cfg.a2_low,
                            flags_reg[3:2], lamp_reg[1]);
    assign key_now  = item.key_down ? {1'b1, item.key_value} : '0;
    assign hold_inc = hold_reg + LIMIT_W'(1);

    always_comb
    begin
        flags_next = flags_reg;
        lamp_next  = lamp_reg;
        prev_next  = prev_reg;
        hold_next  = hold_reg;
        kind_next  = EV_NONE;
        key_next   = '0;
        taken      = 1'b0;
        if (ch1.hit) begin
            flags_next[1:0] = ch1.flags;
            lamp_next[0]    = ch1.lamp;
            kind_next       = EV_A1_HIGH + KIND_W'(ch1.off);
        end else if (ch2.hit) begin
            flags_next[3:2] = ch2.flags;
            lamp_next[1]    = ch2.lamp;
            kind_next       = EV_A2_HIGH + KIND_W'(ch2.off);
        end else begin
            if (key_now != prev_reg) begin
                prev_next = key_now;
                hold_next = '0;
                taken     = 1'b1;
            end else if (hold_inc > cfg.repeat_limit) begin
                hold_next = decay(hold_inc);
                taken     = 1'b1;
            end else begin
                hold_next = hold_inc;
            end
            if (taken) begin
                if (item.key_down) begin
                    kind_next = EV_KEY;
                    key_next  = item.key_value;
                end
            end else if (item.serial_char != CH_NONE) begin
                kind_next = decode_serial(item.serial_char);
            end
        end
    end

    assign out_valid_next = go | (out_valid_reg & ~out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            flags_reg     <= '0;
            lamp_reg      <= '0;
            prev_reg      <= '0;
            hold_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (go) begin
                flags_reg <= flags_next;
                lamp_reg  <= lamp_next;
                prev_reg  <= prev_next;
                hold_reg  <= hold_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go) begin
            kind_reg <= kind_next;
            key_reg  <= key_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign event_kind = kind_reg;
    assign event_key  = key_reg;
    assign lamp_one   = lamp_reg[0];
    assign lamp_two   = lamp_reg[1];

endmodule

// File: rtl/core/dual_alarm_key_serial_event_picker_core.sv
// ----------------------------------------------------------------------------
// dual_alarm_key_serial_event_picker_core
// Two alarm channels, keypad and serial byte in; one event per beat out.
// ----------------------------------------------------------------------------
// Usage:
//   in channel   : in_valid/in_ready, one poll per beat (two levels, key
//                  reading, serial byte).
//   out channel  : out_valid/out_ready, one event per poll with both lamp
//                  states after that poll.
//   cfg channel  : cfg_valid/cfg_ready, always ready; index 0..4 selects the
//                  alarm limits and the repeat limit, other indexes ignored.
//                  Write only while no poll is in flight.
// Path: a poll waits in the input register; its event is then registered
//   in the result register. Throughput: one poll per cycle while results
//   are taken; the event pick logic between the two registers is combinational.
// Reset: limits return to defaults, alarm flags, lamps, last key and hold
//   count clear, both channels empty.
// Stall: while out_ready is low the result holds; the input register still
//   takes one more poll, then in_ready drops until the result is taken.
// ----------------------------------------------------------------------------
module dual_alarm_key_serial_event_picker_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [dakep_pkg::LEVEL_W-1:0]     level_one,
    input  logic [dakep_pkg::LEVEL_W-1:0]     level_two,
    input  logic                              key_down,
    input  logic [dakep_pkg::CODE_W-1:0]      key_value,
    input  logic [dakep_pkg::CODE_W-1:0]      serial_char,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [dakep_pkg::KIND_W-1:0]      event_kind,
    output logic [dakep_pkg::CODE_W-1:0]      event_key,
    output logic                              lamp_one,
    output logic                              lamp_two,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [dakep_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dakep_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import dakep_pkg::*;

    dakep_cfg_t  cfg;
    dakep_item_t item_reg;
    logic        item_valid_reg, item_valid_next;
    logic        go;
    logic        accept;

    assign go       = item_valid_reg & (~out_valid | out_ready);
    assign in_ready = ~item_valid_reg | go;
    assign accept   = in_valid & in_ready;
    assign item_valid_next = accept | (item_valid_reg & ~go);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            item_valid_reg <= 1'b0;
        end else begin
            item_valid_reg <= item_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            item_reg.level_one   <= level_one;
            item_reg.level_two   <= level_two;
            item_reg.key_down    <= key_down;
            item_reg.key_value   <= key_value;
            item_reg.serial_char <= serial_char;
        end
    end

    dakep_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    dakep_pick u_pick (
        .clk        (clk),
        .rst_n      (rst_n),
        .go         (go),
        .item       (item_reg),
        .cfg        (cfg),
        .out_ready  (out_ready),
        .out_valid  (out_valid),
        .event_kind (event_kind),
        .event_key  (event_key),
        .lamp_one   (lamp_one),
        .lamp_two   (lamp_two)
    );

`ifndef SYNTHESIS
    a_key_only_on_key: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_kind != EV_KEY |-> event_key == '0)
        else $error("event_key set on non-key event");

    a_a1_lamp: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_kind == EV_A1_HIGH || event_kind == EV_A1_LOW)
        |-> lamp_one)
        else $error("alarm one event without lamp");

    a_a2_ok_lamp: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_kind == EV_A2_OK |-> !lamp_two)
        else $error("alarm two ok with lamp on");

    a_item_kept: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid_reg && !go |=> item_valid_reg)
        else $error("pending poll dropped");
`endif

endmodule
